>>> hw/rtl/bzenv_pkg.sv
// ----------------------------------------------------------------------------
// bzenv_pkg
// Shared types, sound codes and envelope helper for the buzzer envelope core.
// ----------------------------------------------------------------------------
package bzenv_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [3:0] SND_OFF      = 4'd0;
  localparam logic [3:0] SND_KEYBOARD = 4'd1;
  localparam logic [3:0] SND_INFO     = 4'd2;
  localparam logic [3:0] SND_SAVE     = 4'd3;
  localparam logic [3:0] SND_SELECT   = 4'd4;
  localparam logic [3:0] SND_COMPLETE = 4'd5;
  localparam logic [3:0] SND_START    = 4'd6;
  localparam logic [3:0] SND_POLARITY = 4'd7;
  localparam logic [3:0] SND_ERROR    = 4'd8;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned K10_W   = 13;
  localparam int unsigned M2K_W   = 11;
  localparam int unsigned LVL_W   = 5;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned VOLM_W  = 18;
  localparam int unsigned SCALE_SH = 17;

  // 1311 / 2^17 approximates 1/100; exact floor for products up to 2540
  localparam logic [10:0] RECIP_100 = 11'd1311;
  localparam logic [VOL_W-1:0]  VOL_RST  = 7'd100;
  localparam logic [VOLM_W-1:0] VOLM_RST = 18'd131100;

  localparam logic [3:0]       DIG_LAST  = 4'd9;
  localparam logic [5:0]       K40_LAST  = 6'd39;
  localparam logic [M2K_W-1:0] M2K_LAST  = 11'd1999;

  localparam logic [K10_W-1:0] SAVE_LIM  = 13'd140;
  localparam logic [K10_W-1:0] CMPL_LIM  = 13'd440;
  localparam logic [K10_W-1:0] POL_LIM   = 13'd80;
  localparam logic [14:0]      KEY_LIM   = 15'd20;
  localparam logic [13:0]      SEL_LIM   = 14'd200;
  localparam logic [13:0]      SEL_OFS   = 14'd40;

  localparam logic [5:0] SPAN_10 = 6'd10;
  localparam logic [5:0] SPAN_20 = 6'd20;

  localparam logic [2:0] ADDR_VOLUME = 3'd0;

  typedef struct packed {
    logic       opcode;
    logic [3:0] sound_code;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
  } out_item_t;

  // triangle: 0 outside (0, 2s], rising to s, then falling
  function automatic logic [LVL_W-1:0] tri_lvl(input logic [M2K_W-1:0] t,
                                               input logic [5:0] s);
    logic [M2K_W-1:0] s1;
    logic [M2K_W-1:0] s2;
    logic [M2K_W-1:0] d;
    s1 = {{(M2K_W-6){1'b0}}, s};
    s2 = {{(M2K_W-7){1'b0}}, s, 1'b0};
    d  = s2 - t;
    if (t > s2) begin
      tri_lvl = '0;
    end else if (t > s1) begin
      tri_lvl = d[LVL_W-1:0];
    end else begin
      tri_lvl = t[LVL_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/bzenv_in_if.sv
// ----------------------------------------------------------------------------
// bzenv_in_if
// Input channel: start and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bzenv_in_if;
  import bzenv_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bzenv_out_if.sv
// ----------------------------------------------------------------------------
// bzenv_out_if
// Result channel: scaled buzzer level items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bzenv_out_if;
  import bzenv_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/buzzer_envelope_generator_core.sv
// ----------------------------------------------------------------------------
// buzzer_envelope_generator_core
// Triangular buzzer envelope per sound, scaled by volume, changes only.
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless a held result stalls the input; a
// result goes through the input register, then the result register.
// A result held by the receiver stalls the input register, and then the
// input. The tick count is
// kept alongside its decimal, modulo-40 and modulo-2000 counters, so each
// item needs only compares and one multiply by the prescaled volume, which
// is set by the register write. Volume sits at byte address 0.
module buzzer_envelope_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  bzenv_in_if.sink            in_if,
  bzenv_out_if.source         out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bzenv_pkg::*;

  logic                 s1_valid_r;
  in_item_t             s1_item_r;
  logic                 out_valid_r;
  logic [LVL_W-1:0]     out_level_r;

  logic [3:0]           snd_r, snd_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [3:0]           r10_r, r10_nxt;
  logic [K10_W-1:0]     k10_r, k10_nxt;
  logic [5:0]           k40_r, k40_nxt;
  logic [M2K_W-1:0]     m2k_r, m2k_nxt;
  logic [LVL_W-1:0]     last_r, last_nxt;
  logic [VOL_W-1:0]     vol_r;
  logic [VOLM_W-1:0]    volm_r;

  logic                 out_free;
  logic                 s1_go;
  logic                 emit;
  logic [LVL_W-1:0]     raw;
  logic [LVL_W-1:0]     level;
  logic [22:0]          prod;
  logic [14:0]          k2;
  logic [13:0]          k4;
  logic [13:0]          k4_ofs;
  logic                 cfg_wr;

  assign out_free     = !out_valid_r || out_if.ready;
  assign s1_go        = s1_valid_r && out_free;
  assign in_if.ready  = !s1_valid_r || out_free;
  assign out_if.valid = out_valid_r;
  assign out_if.data.level = out_level_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_VOLUME[2]) ? {25'd0, vol_r} : 32'd0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_VOLUME[2]);

  assign k2     = n_nxt[CNT_W-1:1];
  assign k4     = n_nxt[CNT_W-1:2];
  assign k4_ofs = k4 - SEL_OFS;

  // load the sound and clear counters on a start, else advance them and form the envelope
  always_comb begin
    snd_nxt  = snd_r;
    n_nxt    = n_r;
    r10_nxt  = r10_r;
    k10_nxt  = k10_r;
    k40_nxt  = k40_r;
    m2k_nxt  = m2k_r;
    raw      = '0;
    if (s1_item_r.opcode == OP_START) begin
      snd_nxt = s1_item_r.sound_code;
      n_nxt   = '0;
      r10_nxt = '0;
      k10_nxt = '0;
      k40_nxt = '0;
      m2k_nxt = '0;
    end else begin
      n_nxt = n_r + 16'd1;
      if (n_nxt == '0) begin
        r10_nxt = '0;
        k10_nxt = '0;
        k40_nxt = '0;
        m2k_nxt = '0;
      end else begin
        m2k_nxt = (m2k_r == M2K_LAST) ? '0 : m2k_r + 11'd1;
        if (r10_r == DIG_LAST) begin
          r10_nxt = '0;
          k10_nxt = k10_r + 13'd1;
          k40_nxt = (k40_r == K40_LAST) ? '0 : k40_r + 6'd1;
        end else begin
          r10_nxt = r10_r + 4'd1;
        end
      end
      case (snd_r)
        SND_KEYBOARD: begin
          if (k2 > KEY_LIM) begin
            snd_nxt = SND_OFF;
          end else begin
            raw = tri_lvl(k2[M2K_W-1:0], SPAN_10);
          end
        end
        SND_INFO: begin
          raw = tri_lvl(m2k_nxt, SPAN_10);
        end
        SND_SAVE: begin
          if (k10_nxt > SAVE_LIM) begin
            snd_nxt = SND_OFF;
          end else begin
            raw = tri_lvl(k10_nxt[M2K_W-1:0], SPAN_20);
          end
        end
        SND_SELECT, SND_START: begin
          if (k4 > SEL_LIM) begin
            snd_nxt = SND_OFF;
          end else if (k4 >= SEL_OFS) begin
            raw = tri_lvl(k4[M2K_W-1:0], SPAN_10)
                + tri_lvl(k4_ofs[M2K_W-1:0], SPAN_10);
          end else begin
            raw = tri_lvl(k4[M2K_W-1:0], SPAN_10);
          end
        end
        SND_COMPLETE, SND_ERROR: begin
          if (k10_nxt >= CMPL_LIM) begin
            snd_nxt = SND_OFF;
          end else begin
            raw = tri_lvl({5'd0, k40_nxt}, SPAN_20);
          end
        end
        SND_POLARITY: begin
          if (k10_nxt > POL_LIM) begin
            snd_nxt = SND_OFF;
          end else begin
            raw = tri_lvl({5'd0, k40_nxt}, SPAN_20);
          end
        end
        default: begin
          raw = '0;
        end
      endcase
    end
  end

  assign prod  = {18'd0, raw} * {5'd0, volm_r};
  assign level = prod[SCALE_SH+LVL_W-1:SCALE_SH];
  assign emit  = (s1_item_r.opcode == OP_TICK) && (level != last_r);
  assign last_nxt = emit ? level : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      snd_r       <= SND_OFF;
      n_r         <= '0;
      r10_r       <= '0;
      k10_r       <= '0;
      k40_r       <= '0;
      m2k_r       <= '0;
      last_r      <= '0;
      vol_r       <= VOL_RST;
      volm_r      <= VOLM_RST;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_go && emit;
      end
      if (s1_go) begin
        snd_r  <= snd_nxt;
        n_r    <= n_nxt;
        r10_r  <= r10_nxt;
        k10_r  <= k10_nxt;
        k40_r  <= k40_nxt;
        m2k_r  <= m2k_nxt;
        last_r <= last_nxt;
      end
      if (cfg_wr) begin
        vol_r  <= pwdata[VOL_W-1:0];
        volm_r <= VOLM_W'({11'd0, pwdata[VOL_W-1:0]} * {7'd0, RECIP_100});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_item_r <= in_if.data;
    end
    if (out_free && s1_go && emit) begin
      out_level_r <= level;
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buzzer envelope core: drives start and tick
// items with random gaps, runs every sound from its start, takes the
// keyboard sound past its time limit, and compares each level change against
// a local predictor or fixed script values across several volume settings.
// ----------------------------------------------------------------------------
module tb_top;
  import bzenv_pkg::*;

  localparam int         CYCLE_LIMIT   = 60_000;
  localparam int         LONG_HOLD     = 60;
  localparam logic [3:0] SND_UNUSED_LO = 4'd9;
  localparam logic [3:0] SND_UNUSED_HI = 4'd15;

  typedef struct {
    logic       op;
    logic [3:0] code;
    bit         known;
    bit         has;
    logic [4:0] lvl;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bzenv_in_if  in_if ();
  bzenv_out_if out_if ();

  buzzer_envelope_generator_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [3:0]  sound_now;
  logic [15:0] tick_count;
  logic [4:0]  level_now;
  logic [6:0]  volume_now;
  logic [4:0]  levels_due [$];
  logic [4:0]  due_lvl;
  int          mismatches;
  int          cycles;
  bit          no_idle;
  bit          hold_req;

  int sweep_len [9] = '{4, 46, 60, 30, 30, 30, 30, 30, 30};

  script_row_t script [24] = '{
    '{OP_TICK,  SND_UNUSED_HI, 1'b1, 1'b0, 5'd0},
    '{OP_START, SND_UNUSED_HI, 1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b1, 1'b0, 5'd0},
    '{OP_START, SND_KEYBOARD,  1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_UNUSED_HI, 1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b1, 1'b1, 5'd1},
    '{OP_START, SND_INFO,      1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b1, 1'b1, 5'd2},
    '{OP_START, SND_SAVE,      1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b1, 1'b1, 5'd0},
    '{OP_START, SND_SELECT,    1'b1, 1'b0, 5'd0},
    '{OP_START, SND_START,     1'b1, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b0, 1'b0, 5'd0},
    '{OP_START, SND_COMPLETE,  1'b0, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b0, 1'b0, 5'd0},
    '{OP_START, SND_POLARITY,  1'b0, 1'b0, 5'd0},
    '{OP_TICK,  SND_UNUSED_HI, 1'b0, 1'b0, 5'd0},
    '{OP_START, SND_ERROR,     1'b0, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b0, 1'b0, 5'd0},
    '{OP_START, SND_UNUSED_LO, 1'b0, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b0, 1'b0, 5'd0},
    '{OP_START, SND_OFF,       1'b0, 1'b0, 5'd0},
    '{OP_TICK,  SND_OFF,       1'b0, 1'b0, 5'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int triangle(input int t, input int s);
    if (t > 2 * s) return 0;
    if (t > s) return 2 * s - t;
    if (t > 0) return t;
    return 0;
  endfunction

  task automatic step_buzzer(input logic op, input logic [3:0] code,
                             output bit has, output logic [4:0] lvl);
    int n;
    int k;
    int raw;
    int scaled;
    has = 1'b0;
    lvl = level_now;
    if (op == OP_START) begin
      sound_now  = code;
      tick_count = '0;
      return;
    end
    tick_count = tick_count + 16'd1;
    n   = int'(tick_count);
    raw = 0;
    case (sound_now)
      SND_KEYBOARD: begin
        k = n / 2;
        if (k > 20) sound_now = SND_OFF;
        else raw = triangle(k, 10);
      end
      SND_INFO: raw = triangle(n % 2000, 10);
      SND_SAVE: begin
        k = n / 10;
        if (k > 140) sound_now = SND_OFF;
        else raw = triangle(k, 20);
      end
      SND_SELECT, SND_START: begin
        k = n / 4;
        if (k > 200) sound_now = SND_OFF;
        else raw = triangle(k, 10) + triangle(k - 40, 10);
      end
      SND_COMPLETE, SND_ERROR: begin
        k = n / 10;
        if (k / 40 > 10) sound_now = SND_OFF;
        else raw = triangle(k % 40, 20);
      end
      SND_POLARITY: begin
        k = n / 10;
        if (k > 80) sound_now = SND_OFF;
        else raw = triangle(k % 40, 20);
      end
      default: raw = 0;
    endcase
    scaled = (raw * int'(volume_now)) / 100;
    lvl = 5'(scaled);
    if (lvl != level_now) begin
      has       = 1'b1;
      level_now = lvl;
    end
  endtask

  task automatic send_item(input logic op, input logic [3:0] code,
                           input bit known = 1'b0, input bit k_has = 1'b0,
                           input logic [4:0] k_lvl = '0);
    int         gap;
    bit         has;
    logic [4:0] lvl;
    gap = no_idle ? 0 : $urandom_range(4);
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {op, code};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    step_buzzer(op, code, has, lvl);
    if (known) begin
      has = k_has;
      lvl = k_lvl;
    end
    if (has) levels_due.push_back(lvl);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_VOLUME;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic check_volume();
    logic [31:0] rd;
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {25'd0, volume_now}) begin
      $display("%0t: volume readback mismatch, expected %0d, actual %0d",
               $time, volume_now, rd);
      mismatches++;
    end
  endtask

  task automatic set_volume(input logic [6:0] vol);
    logic [31:0] rd;
    apb_xfer(1'b1, {25'd0, vol}, rd);
    volume_now = vol;
    check_volume();
  endtask

  task automatic random_phase(input int n_items);
    int         sent;
    int         len;
    logic [3:0] code;
    sent = 0;
    while (sent < n_items) begin
      no_idle = ($urandom_range(3) == 0);
      if ($urandom_range(4) != 0) begin
        if ($urandom_range(5) == 0) code = 4'($urandom_range(15));
        else code = 4'($urandom_range(SND_ERROR, SND_KEYBOARD));
        send_item(OP_START, code);
        len = $urandom_range(40, 1);
        repeat (len) send_item(OP_TICK, 4'($urandom));
        sent += len + 1;
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_item(1'($urandom), 4'($urandom));
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver: random gap per item, one long hold on request
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = no_idle ? 0 : $urandom_range(4);
      end
      repeat (gap) begin
        out_if.ready <= 1'b0;
        @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected level, expected none, actual %0d",
                 $time, out_if.data.level);
        mismatches++;
      end else begin
        due_lvl = levels_due.pop_front();
        if (out_if.data.level !== due_lvl) begin
          $display("%0t: level mismatch, expected %0d, actual %0d",
                   $time, due_lvl, out_if.data.level);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches  = 0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    sound_now   = SND_OFF;
    tick_count  = '0;
    level_now   = '0;
    volume_now  = VOL_RST;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_volume();

    foreach (script[i])
      send_item(script[i].op, script[i].code, script[i].known,
                script[i].has, script[i].lvl);
    settle();

    // run every sound from its start at full-scale volume
    set_volume(7'd127);
    for (int c = SND_KEYBOARD; c <= SND_ERROR; c++) begin
      no_idle = (c == SND_INFO);
      if (c == SND_INFO) hold_req = 1'b1;
      send_item(OP_START, 4'(c));
      repeat (sweep_len[c]) send_item(OP_TICK, 4'($urandom));
    end
    no_idle = 1'b0;
    settle();

    set_volume(7'd0);
    random_phase(40);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       set_volume(7'd127);
        2:       set_volume(7'd1);
        default: set_volume(7'($urandom_range(126, 2)));
      endcase
      random_phase(45);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
